FILE: rtl/core/sit_pkg.sv
// Shared types, widths and codes of the segment intersection test.
`timescale 1ns / 1ps

package sit_pkg;

  // Coordinate format and derived arithmetic widths
  localparam int unsigned CoordBits = 16;
  localparam int unsigned TolBits   = 34;
  localparam int unsigned DifW      = CoordBits + 1;         // coordinate difference
  localparam int unsigned CrsW      = 2 * DifW + 1;          // cross product, determinant
  localparam int unsigned CoefW     = 2 * CoordBits + 1;     // line constant c
  localparam int unsigned NumW      = CoefW + DifW + 1;      // Cramer numerator
  localparam int unsigned TcmpW     = (CrsW > TolBits) ? CrsW : TolBits;
  localparam int unsigned RemW      = (NumW > CrsW + CoordBits) ? NumW : CrsW + CoordBits;
  localparam int unsigned DivLat    = CoordBits + 2;         // divider register layers

  // Queue between front and back
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = TolBits;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_X   = 3'd0,
    CFG_START_Y   = 3'd1,
    CFG_END_X     = 3'd2,
    CFG_END_Y     = 3'd3,
    CFG_TOLERANCE = 3'd4
  } cfg_idx_e;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t query_start_x;
    coord_t query_start_y;
    coord_t query_end_x;
    coord_t query_end_y;
    logic   count_collinear;
  } seg_in_t;

  typedef struct packed {
    logic   segments_meet;
    logic   lines_parallel;
    coord_t meet_x;
    coord_t meet_y;
    logic   point_saturated;
  } seg_out_t;

  typedef struct packed {
    coord_t               start_x;
    coord_t               start_y;
    coord_t               end_x;
    coord_t               end_y;
    logic [TolBits-1:0]   tolerance;
  } ref_cfg_t;

  // Classified query handed from front to back
  typedef struct packed {
    logic                   meet;
    logic                   parallel;
    logic signed [NumW-1:0] num_x;
    logic signed [NumW-1:0] num_y;
    logic signed [CrsW-1:0] det;
  } geo_t;

  typedef struct packed {
    logic meet;
    logic parallel;
  } flags_t;

endpackage

FILE: rtl/core/segment_intersection_test.sv
// Top level of the segment intersection test against a configured reference segment.
// Usage:
//   Write the reference segment (indexes 0..3, signed Q8.8) and the tolerance
//   (index 4) through cfg_we_i / cfg_idx_i / cfg_data_i while the block is idle;
//   writes to other indexes are ignored. Reset clears configuration and control state.
//   Each query transaction on in_valid_i / in_ready_o carries a query segment and
//   the collinear flag; exactly one result transaction follows on out_valid_o /
//   out_ready_i, in order.
// Timing:
//   One transaction per cycle is accepted and delivered in steady state while the
//   receiver is ready. From acceptance to result valid a transaction passes five
//   front stages of differences, multiplies and classification, the queue, and
//   nineteen back stages: the one-bit-per-stage divider for the meeting point
//   plus the output register.
//   When the receiver stalls, the back holds its pipeline, the two-entry queue
//   fills, then the front holds and in_ready_o drops; nothing is lost.
`timescale 1ns / 1ps

module segment_intersection_test (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sit_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [sit_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  sit_pkg::seg_in_t                   in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output sit_pkg::seg_out_t                  out_data_o
);

  localparam int unsigned CoordBits = sit_pkg::CoordBits;
  localparam int unsigned TolBits   = sit_pkg::TolBits;

  sit_pkg::ref_cfg_t cfg_q;
  logic              mid_valid, mid_ready, q_valid, q_ready;
  sit_pkg::geo_t     mid_data, q_data;

  // Register configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (sit_pkg::cfg_idx_e'(cfg_idx_i))
        sit_pkg::CFG_START_X:   cfg_q.start_x   <= cfg_data_i[CoordBits-1:0];
        sit_pkg::CFG_START_Y:   cfg_q.start_y   <= cfg_data_i[CoordBits-1:0];
        sit_pkg::CFG_END_X:     cfg_q.end_x     <= cfg_data_i[CoordBits-1:0];
        sit_pkg::CFG_END_Y:     cfg_q.end_y     <= cfg_data_i[CoordBits-1:0];
        sit_pkg::CFG_TOLERANCE: cfg_q.tolerance <= cfg_data_i[TolBits-1:0];
        default: ;
      endcase
    end
  end

  sit_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_data_o  (mid_data)
  );

  sit_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (mid_valid),
    .push_ready_o (mid_ready),
    .push_data_i  (mid_data),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  sit_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/core/sit_front.sv
// Front part: accepts queries, computes orientations, hit and parallel flags and Cramer numerators.
`timescale 1ns / 1ps

module sit_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sit_pkg::ref_cfg_t  cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sit_pkg::seg_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sit_pkg::geo_t      out_data_o
);

  localparam int unsigned CoordBits = sit_pkg::CoordBits;
  localparam int unsigned DifW      = sit_pkg::DifW;
  localparam int unsigned CrsW      = sit_pkg::CrsW;
  localparam int unsigned CoefW     = sit_pkg::CoefW;
  localparam int unsigned NumW      = sit_pkg::NumW;
  localparam int unsigned TolBits   = sit_pkg::TolBits;
  localparam int unsigned TcmpW     = sit_pkg::TcmpW;

  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_CCW = 2'd2
  } orient_e;

  // Magnitude of a cross product below the tolerance
  function automatic logic below_tol(logic signed [CrsW-1:0] v, logic [TolBits-1:0] tol);
    logic [CrsW-1:0] m;
    m = v[CrsW-1] ? CrsW'(-v) : CrsW'(v);
    return TcmpW'(m) < TcmpW'(tol);
  endfunction

  function automatic orient_e classify(logic signed [CrsW-1:0] v, logic [TolBits-1:0] tol);
    orient_e o;
    if (below_tol(v, tol)) begin
      o = ORI_COL;
    end else if (!v[CrsW-1] && (v != '0)) begin
      o = ORI_CW;
    end else begin
      o = ORI_CCW;
    end
    return o;
  endfunction

  // Point b inside the closed bounding box of a and c
  function automatic logic in_box(sit_pkg::coord_t ax, sit_pkg::coord_t ay,
                                  sit_pkg::coord_t bx, sit_pkg::coord_t by,
                                  sit_pkg::coord_t cx, sit_pkg::coord_t cy);
    logic x_in, y_in;
    x_in = ((bx >= ax) && (bx <= cx)) || ((bx >= cx) && (bx <= ax));
    y_in = ((by >= ay) && (by <= cy)) || ((by >= cy) && (by <= ay));
    return x_in && y_in;
  endfunction

  logic adv;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;

  sit_pkg::coord_t sx, sy, ex, ey, px, py, tx, ty;

  // stage 1: differences and box tests
  logic signed [DifW-1:0] rdx_q, rdy_q, qdx_q, qdy_q;
  logic signed [DifW-1:0] pex_q, pey_q, tex_q, tey_q, stx_q, sty_q, etx_q, ety_q;
  sit_pkg::coord_t        px_q, py_q, tx_q, ty_q;
  logic [3:0]             box1_q;
  logic                   col1_q;

  // stage 2: products
  logic signed [2*DifW-1:0]      v1a_q, v1b_q, v2a_q, v2b_q, v3a_q, v3b_q, v4a_q, v4b_q;
  logic signed [2*DifW-1:0]      da_q, db_q;
  logic signed [2*CoordBits-1:0] c1a_q, c1b_q, c2a_q, c2b_q;
  logic signed [DifW-1:0]        rdx2_q, rdy2_q, qdx2_q, qdy2_q;
  logic [3:0]                    box2_q;
  logic                          col2_q;

  // stage 3: cross products, determinant, line constants
  logic signed [CrsW-1:0]  v1_q, v2_q, v3_q, v4_q, det3_q;
  logic signed [CoefW-1:0] c1_q, c2_q;
  logic signed [DifW-1:0]  rdx3_q, rdy3_q, qdx3_q, qdy3_q;
  logic [3:0]              box3_q;
  logic                    col3_q;

  // stage 4: classification and numerator products
  logic signed [CoefW+DifW-1:0] pxa_q, pxb_q, pya_q, pyb_q;
  logic signed [CrsW-1:0]       det4_q;
  logic                         meet4_q, par4_q;

  // stage 5: numerators
  sit_pkg::geo_t out_q;

  orient_e o1, o2, o3, o4;
  logic    meet_gen, meet_col, par;

  assign sx = cfg_i.start_x;
  assign sy = cfg_i.start_y;
  assign ex = cfg_i.end_x;
  assign ey = cfg_i.end_y;
  assign px = in_data_i.query_start_x;
  assign py = in_data_i.query_start_y;
  assign tx = in_data_i.query_end_x;
  assign ty = in_data_i.query_end_y;

  // Advance the whole front unless the last stage is blocked by a full queue
  assign adv         = !s5_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = s5_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  // Stage 1: take differences of the transaction's points
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdx_q  <= DifW'($signed(ex)) - DifW'($signed(sx));
      rdy_q  <= DifW'($signed(ey)) - DifW'($signed(sy));
      qdx_q  <= DifW'($signed(tx)) - DifW'($signed(px));
      qdy_q  <= DifW'($signed(ty)) - DifW'($signed(py));
      pex_q  <= DifW'($signed(px)) - DifW'($signed(ex));
      pey_q  <= DifW'($signed(py)) - DifW'($signed(ey));
      tex_q  <= DifW'($signed(tx)) - DifW'($signed(ex));
      tey_q  <= DifW'($signed(ty)) - DifW'($signed(ey));
      stx_q  <= DifW'($signed(sx)) - DifW'($signed(tx));
      sty_q  <= DifW'($signed(sy)) - DifW'($signed(ty));
      etx_q  <= DifW'($signed(ex)) - DifW'($signed(tx));
      ety_q  <= DifW'($signed(ey)) - DifW'($signed(ty));
      px_q   <= px;
      py_q   <= py;
      tx_q   <= tx;
      ty_q   <= ty;
      box1_q <= {in_box(px, py, ex, ey, tx, ty),
                 in_box(px, py, sx, sy, tx, ty),
                 in_box(sx, sy, tx, ty, ex, ey),
                 in_box(sx, sy, px, py, ex, ey)};
      col1_q <= in_data_i.count_collinear;
    end
  end

  // Stage 2: multiply
  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1a_q  <= rdy_q * pex_q;
      v1b_q  <= rdx_q * pey_q;
      v2a_q  <= rdy_q * tex_q;
      v2b_q  <= rdx_q * tey_q;
      v3a_q  <= qdy_q * stx_q;
      v3b_q  <= qdx_q * sty_q;
      v4a_q  <= qdy_q * etx_q;
      v4b_q  <= qdx_q * ety_q;
      da_q   <= rdx_q * qdy_q;
      db_q   <= rdy_q * qdx_q;
      c1a_q  <= ex * sy;
      c1b_q  <= sx * ey;
      c2a_q  <= tx_q * py_q;
      c2b_q  <= px_q * ty_q;
      rdx2_q <= rdx_q;
      rdy2_q <= rdy_q;
      qdx2_q <= qdx_q;
      qdy2_q <= qdy_q;
      box2_q <= box1_q;
      col2_q <= col1_q;
    end
  end

  // Stage 3: subtract product pairs
  always_ff @(posedge clk_i) begin
    if (adv) begin
      v1_q   <= CrsW'(v1a_q) - CrsW'(v1b_q);
      v2_q   <= CrsW'(v2a_q) - CrsW'(v2b_q);
      v3_q   <= CrsW'(v3a_q) - CrsW'(v3b_q);
      v4_q   <= CrsW'(v4a_q) - CrsW'(v4b_q);
      det3_q <= CrsW'(da_q) - CrsW'(db_q);
      c1_q   <= CoefW'(c1a_q) - CoefW'(c1b_q);
      c2_q   <= CoefW'(c2a_q) - CoefW'(c2b_q);
      rdx3_q <= rdx2_q;
      rdy3_q <= rdy2_q;
      qdx3_q <= qdx2_q;
      qdy3_q <= qdy2_q;
      box3_q <= box2_q;
      col3_q <= col2_q;
    end
  end

  // Classify the four triples, decide the hit and detect parallel lines
  always_comb begin
    o1       = classify(v1_q, cfg_i.tolerance);
    o2       = classify(v2_q, cfg_i.tolerance);
    o3       = classify(v3_q, cfg_i.tolerance);
    o4       = classify(v4_q, cfg_i.tolerance);
    meet_gen = (o1 != o2) && (o3 != o4);
    meet_col = col3_q && (((o1 == ORI_COL) && box3_q[0]) || ((o2 == ORI_COL) && box3_q[1]) ||
                          ((o3 == ORI_COL) && box3_q[2]) || ((o4 == ORI_COL) && box3_q[3]));
    par      = (det3_q == '0) || below_tol(det3_q, cfg_i.tolerance);
  end

  // Stage 4: flags and numerator products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      meet4_q <= meet_gen || meet_col;
      par4_q  <= par;
      pxa_q   <= c1_q * qdx3_q;
      pxb_q   <= rdx3_q * c2_q;
      pya_q   <= c1_q * qdy3_q;
      pyb_q   <= rdy3_q * c2_q;
      det4_q  <= det3_q;
    end
  end

  // Stage 5: numerators, ready for the queue
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.meet     <= meet4_q;
      out_q.parallel <= par4_q;
      out_q.num_x    <= NumW'(pxa_q) - NumW'(pxb_q);
      out_q.num_y    <= NumW'(pya_q) - NumW'(pyb_q);
      out_q.det      <= det4_q;
    end
  end

endmodule

FILE: rtl/core/sit_fifo.sv
// Short queue between the front and the back part.
`timescale 1ns / 1ps

module sit_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  sit_pkg::geo_t  push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output sit_pkg::geo_t  pop_data_o
);

  localparam int unsigned Depth = sit_pkg::FifoDepth;
  localparam int unsigned PtrW  = sit_pkg::FifoPtrW;
  localparam int unsigned CntW  = sit_pkg::FifoCntW;

  sit_pkg::geo_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Track fill level and pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/core/sit_div.sv
// Pipelined restoring divider: magnitude quotient of a numerator by the determinant.
`timescale 1ns / 1ps

module sit_div (
  input  logic                                clk_i,
  input  logic                                adv_i,
  input  logic signed [sit_pkg::NumW-1:0]     num_i,
  input  logic signed [sit_pkg::CrsW-1:0]     den_i,
  output logic [sit_pkg::CoordBits-1:0]       quo_o,
  output logic                                neg_o,
  output logic                                ovf_o
);

  localparam int unsigned Qb   = sit_pkg::CoordBits;
  localparam int unsigned NumW = sit_pkg::NumW;
  localparam int unsigned CrsW = sit_pkg::CrsW;
  localparam int unsigned RemW = sit_pkg::RemW;

  logic [RemW-1:0] nmag_q;
  logic [CrsW-1:0] dmag_q;
  logic            nneg_q;

  logic [RemW-1:0] rem_q [Qb+1];
  logic [CrsW-1:0] den_q [Qb+1];
  logic [Qb-1:0]   quo_q [Qb+1];
  logic            neg_q [Qb+1];
  logic            ovf_q [Qb+1];

  // Take magnitudes and the quotient sign
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      nmag_q <= RemW'(num_i[NumW-1] ? NumW'(-num_i) : NumW'(num_i));
      dmag_q <= den_i[CrsW-1] ? CrsW'(-den_i) : CrsW'(den_i);
      nneg_q <= num_i[NumW-1] ^ den_i[CrsW-1];
    end
  end

  // Flag quotients that do not fit the coordinate width
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ovf_q[0] <= nmag_q >= (RemW'(dmag_q) << Qb);
      rem_q[0] <= nmag_q;
      den_q[0] <= dmag_q;
      quo_q[0] <= '0;
      neg_q[0] <= nneg_q;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 1; k <= Qb; k++) begin : g_step
    logic [RemW-1:0] shifted, diff;
    logic            take;

    always_comb begin
      shifted = RemW'(den_q[k-1]) << (Qb - k);
      take    = rem_q[k-1] >= shifted;
      diff    = rem_q[k-1] - shifted;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= take ? diff : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        quo_q[k] <= {quo_q[k-1][Qb-2:0], take};
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  assign quo_o = quo_q[Qb];
  assign neg_o = neg_q[Qb];
  assign ovf_o = ovf_q[Qb];

endmodule

FILE: rtl/core/sit_back.sv
// Back part: divides the numerators, saturates the meeting point, holds the result.
`timescale 1ns / 1ps

module sit_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sit_pkg::geo_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sit_pkg::seg_out_t out_data_o
);

  localparam int unsigned CoordBits = sit_pkg::CoordBits;
  localparam int unsigned Lat       = sit_pkg::DivLat;

  // Signed quotient clipped to the coordinate range, saturation flag on top
  function automatic logic [CoordBits:0] clip(logic [CoordBits-1:0] quo, logic neg,
                                               logic ovf);
    logic [CoordBits-1:0] hi, lo;
    logic [CoordBits:0]   r;
    hi = {1'b0, {(CoordBits-1){1'b1}}};
    lo = {1'b1, {(CoordBits-1){1'b0}}};
    if (ovf) begin
      r = {1'b1, neg ? lo : hi};
    end else if (!neg) begin
      r = quo[CoordBits-1] ? {1'b1, hi} : {1'b0, quo};
    end else begin
      r = (quo > lo) ? {1'b1, lo} : {1'b0, CoordBits'(-quo)};
    end
    return r;
  endfunction

  logic                  adv;
  logic [Lat-1:0]        vld_q;
  sit_pkg::flags_t       flags_q [Lat];
  logic                  out_vld_q;
  sit_pkg::seg_out_t     out_q;

  logic [CoordBits-1:0]  quo_x, quo_y;
  logic                  neg_x, neg_y, ovf_x, ovf_y;
  logic [CoordBits:0]    clip_x, clip_y;

  // Advance unless a finished result waits for the receiver
  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  sit_div u_div_x (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (in_data_i.num_x),
    .den_i (in_data_i.det),
    .quo_o (quo_x),
    .neg_o (neg_x),
    .ovf_o (ovf_x)
  );

  sit_div u_div_y (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (in_data_i.num_y),
    .den_i (in_data_i.det),
    .quo_o (quo_y),
    .neg_o (neg_y),
    .ovf_o (ovf_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[Lat-2:0], in_valid_i};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  // Carry the flags alongside the dividers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      flags_q[0] <= '{meet: in_data_i.meet, parallel: in_data_i.parallel};
      for (int i = 1; i < Lat; i++) begin
        flags_q[i] <= flags_q[i-1];
      end
    end
  end

  assign clip_x = clip(quo_x, neg_x, ovf_x);
  assign clip_y = clip(quo_y, neg_y, ovf_y);

  // Form the result; parallel lines give no meeting point
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.segments_meet  <= flags_q[Lat-1].meet;
      out_q.lines_parallel <= flags_q[Lat-1].parallel;
      if (flags_q[Lat-1].parallel) begin
        out_q.meet_x          <= '0;
        out_q.meet_y          <= '0;
        out_q.point_saturated <= 1'b0;
      end else begin
        out_q.meet_x          <= clip_x[CoordBits-1:0];
        out_q.meet_y          <= clip_y[CoordBits-1:0];
        out_q.point_saturated <= clip_x[CoordBits] || clip_y[CoordBits];
      end
    end
  end

endmodule
